### rtl/cld_pkg.sv
// ----------------------------------------------------------------------------
// cld_pkg
// Shared types and codes for the caching lock directory.
// ----------------------------------------------------------------------------
package cld_pkg;

  localparam int LOCKS    = 64;
  localparam int CLIENTS  = 16;
  localparam int LOCK_W   = $clog2(LOCKS);
  localparam int CLIENT_W = $clog2(CLIENTS);

  localparam logic CMD_ACQUIRE = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  localparam logic STAT_OK    = 1'b0;
  localparam logic STAT_RETRY = 1'b1;

  typedef enum logic [1:0] {
    MODE_FREE = 2'd0,
    MODE_HELD = 2'd1,
    MODE_WAIT = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    NOTE_NONE   = 2'd0,
    NOTE_REVOKE = 2'd1,
    NOTE_RETRY  = 2'd2
  } note_t;

  typedef struct packed {
    mode_t                mode;
    logic [CLIENT_W-1:0]  holder;
    logic [CLIENT_W-1:0]  next_client;
    logic                 next_valid;
    logic [CLIENTS-1:0]   waiter_map;
  } entry_t;

  localparam entry_t ENTRY_RESET = '{
    mode:        MODE_FREE,
    holder:      '0,
    next_client: '0,
    next_valid:  1'b0,
    waiter_map:  '0
  };

  typedef struct packed {
    logic                status;
    note_t               kind;
    logic [CLIENT_W-1:0] client;
  } reply_t;

endpackage

### rtl/cld_dir_mem.sv
// ----------------------------------------------------------------------------
// cld_dir_mem
// Lock directory store: registered read, write-to-read forwarding, entry valid
// bits so that untouched entries read as unlocked after reset.
// ----------------------------------------------------------------------------
module cld_dir_mem
  import cld_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              rd_en,
  input  logic [LOCK_W-1:0] rd_addr,
  input  logic              wr_en,
  input  logic [LOCK_W-1:0] wr_addr,
  input  entry_t            wr_data,
  output entry_t            rd_data
);

  entry_t             mem_r [LOCKS];
  logic [LOCKS-1:0]   vld_r;
  entry_t             rd_raw_r;
  logic               rd_vld_r;
  logic               fwd_hit_r;
  entry_t             fwd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_raw_r   <= mem_r[rd_addr];
      fwd_data_r <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      rd_vld_r  <= 1'b0;
      fwd_hit_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r  <= vld_r[rd_addr];
        // same-edge write to the entry being read: take the new value
        fwd_hit_r <= wr_en && (wr_addr == rd_addr);
      end
    end
  end

  assign rd_data = fwd_hit_r ? fwd_data_r :
                   rd_vld_r  ? rd_raw_r   : ENTRY_RESET;

endmodule

### rtl/cld_update.sv
// ----------------------------------------------------------------------------
// cld_update
// Next-state and reply logic for one directory entry.
// ----------------------------------------------------------------------------
module cld_update
  import cld_pkg::*;
(
  input  logic                command,
  input  logic [CLIENT_W-1:0] client_id,
  input  entry_t              cur,
  output entry_t              nxt,
  output reply_t              reply
);

  function automatic logic [CLIENT_W-1:0] lowest_set(input logic [CLIENTS-1:0] map);
    logic [CLIENT_W-1:0] idx;
    idx = '0;
    for (int i = CLIENTS - 1; i >= 0; i--) begin
      if (map[i]) begin
        idx = CLIENT_W'(i);
      end
    end
    return idx;
  endfunction

  logic [CLIENTS-1:0] cbit;
  logic [CLIENTS-1:0] left_map;
  logic               desig_waiting;

  assign cbit          = CLIENTS'(1) << client_id;
  assign left_map      = cur.waiter_map & ~cbit;
  assign desig_waiting = cur.next_valid && cur.waiter_map[cur.next_client];

  always_comb begin
    nxt          = cur;
    reply.status = STAT_OK;
    reply.kind   = NOTE_NONE;
    reply.client = '0;
    if (command == CMD_RELEASE) begin
      case (cur.mode)
        MODE_HELD: begin
          nxt.mode   = MODE_FREE;
          nxt.holder = '0;
        end
        MODE_WAIT: begin
          nxt.holder = '0;
          if (cur.next_valid) begin
            reply.kind   = NOTE_RETRY;
            reply.client = cur.next_client;
          end
        end
        default: ;
      endcase
    end else begin
      case (cur.mode)
        MODE_HELD: begin
          nxt.mode        = MODE_WAIT;
          nxt.waiter_map  = cur.waiter_map | cbit;
          nxt.next_client = client_id;
          nxt.next_valid  = 1'b1;
          reply.status    = STAT_RETRY;
          reply.kind      = NOTE_REVOKE;
          reply.client    = cur.holder;
        end
        MODE_WAIT: begin
          if (desig_waiting && (cur.next_client == client_id)) begin
            nxt.holder     = client_id;
            nxt.waiter_map = left_map;
            if (left_map == '0) begin
              nxt.next_valid  = 1'b0;
              nxt.next_client = '0;
              nxt.mode        = MODE_HELD;
            end else begin
              nxt.next_client = lowest_set(left_map);
              nxt.next_valid  = 1'b1;
              reply.kind      = NOTE_REVOKE;
              reply.client    = client_id;
            end
          end else begin
            nxt.waiter_map = cur.waiter_map | cbit;
            reply.status   = STAT_RETRY;
          end
        end
        default: begin
          // free, and the unused mode code, grant straight away
          nxt.mode   = MODE_HELD;
          nxt.holder = client_id;
        end
      endcase
    end
  end

endmodule

### rtl/caching_lock_directory_unit.sv
// ----------------------------------------------------------------------------
// caching_lock_directory_unit
// Lock directory with revoke/retry notices: one request beat in, one reply
// beat out.
// ----------------------------------------------------------------------------
//  channel | handshake             | payload
//  --------+-----------------------+-----------------------------------------------------
//  in      | in_valid / in_ready   | in_command, in_lock_id, in_client_id
//  out     | out_valid / out_ready | out_reply_status, out_notice_kind, out_notice_client
//
//  The accepting edge loads the update stage and issues the directory read; the
//  update stage, when it advances, writes back and registers the reply. One request
//  per cycle sustained while replies drain; a back-to-back request to the same lock is
//  served by forwarding the write-back. Reset clears the entry valid bits at once.
//  A stalled reply holds the update stage and drops in_ready; a request is still
//  taken while the reply waits, as long as the update stage is empty.
// ----------------------------------------------------------------------------
module caching_lock_directory_unit
  import cld_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_command,
  input  logic [LOCK_W-1:0]   in_lock_id,
  input  logic [CLIENT_W-1:0] in_client_id,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_reply_status,
  output logic [1:0]          out_notice_kind,
  output logic [CLIENT_W-1:0] out_notice_client
);

  // update stage
  logic                s1_valid_r, s1_valid_nxt;
  logic                s1_cmd_r;
  logic [LOCK_W-1:0]   s1_lock_r;
  logic [CLIENT_W-1:0] s1_client_r;
  // reply register
  logic                out_valid_r, out_valid_nxt;
  reply_t              out_reply_r;

  logic   s1_adv;
  logic   in_acc;
  entry_t cur_entry;
  entry_t new_entry;
  reply_t new_reply;

  // update stage moves on when the reply register is free or being drained
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_acc   = in_valid && in_ready;

  cld_dir_mem u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_acc),
    .rd_addr (in_lock_id),
    .wr_en   (s1_adv),
    .wr_addr (s1_lock_r),
    .wr_data (new_entry),
    .rd_data (cur_entry)
  );

  cld_update u_upd (
    .command   (s1_cmd_r),
    .client_id (s1_client_r),
    .cur       (cur_entry),
    .nxt       (new_entry),
    .reply     (new_reply)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_cmd_r    <= in_command;
      s1_lock_r   <= in_lock_id;
      s1_client_r <= in_client_id;
    end
    if (s1_adv) begin
      out_reply_r <= new_reply;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_reply_status  = out_reply_r.status;
  assign out_notice_kind   = out_reply_r.kind;
  assign out_notice_client = out_reply_r.client;

`ifndef SYNTHESIS
  // a new beat while the update stage is busy needs that stage to retire
  a_acc_retires: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && s1_valid_r |-> s1_adv)
    else $error("request taken over a stalled update stage");

  // a held update stage keeps its lock so the write-back address is stable
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_adv |=> s1_valid_r && $stable(s1_lock_r))
    else $error("update stage lost its request while stalled");

  // no notice means no addressee
  a_note_client: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_reply_r.kind == NOTE_NONE) |-> out_reply_r.client == '0)
    else $error("notice client set without a notice");

  // a retry notice only comes from a release, which always answers OK
  a_retry_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_reply_r.status == STAT_RETRY) |->
      out_reply_r.kind != NOTE_RETRY)
    else $error("retry notice on a RETRY reply");
`endif

endmodule
